// ===== rtl/stl_pkg.sv =====
// ----------------------------------------------------------------------------
// stl_pkg
// Types, token codes and the keyword table of the SQL token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

  typedef enum logic [15:0] {
    M_IDLE    = 16'h0001,
    M_OP      = 16'h0002,
    M_MINUS   = 16'h0004,
    M_XP      = 16'h0008,
    M_BP      = 16'h0010,
    M_ZERO    = 16'h0020,
    M_ID      = 16'h0040,
    M_NUM     = 16'h0080,
    M_EXPS    = 16'h0100,
    M_EXPD    = 16'h0200,
    M_STR     = 16'h0400,
    M_ESC     = 16'h0800,
    M_HEXQ    = 16'h1000,
    M_HEX2    = 16'h2000,
    M_BITQ    = 16'h4000,
    M_DISCARD = 16'h8000
  } mode_e;

  // token kinds
  localparam logic [3:0] KD_SYM    = 4'd0;
  localparam logic [3:0] KD_POINT  = 4'd1;
  localparam logic [3:0] KD_ASSIGN = 4'd2;
  localparam logic [3:0] KD_CMP    = 4'd3;
  localparam logic [3:0] KD_LOG    = 4'd4;
  localparam logic [3:0] KD_NUM    = 4'd5;
  localparam logic [3:0] KD_STR    = 4'd6;
  localparam logic [3:0] KD_INT    = 4'd7;
  localparam logic [3:0] KD_FLT    = 4'd8;
  localparam logic [3:0] KD_KEY    = 4'd9;
  localparam logic [3:0] KD_AGG    = 4'd10;
  localparam logic [3:0] KD_NAME   = 4'd11;
  localparam logic [3:0] KD_NONE   = 4'd15;

  // token codes
  localparam logic [6:0] CD_NONE  = 7'd0;
  localparam logic [6:0] CD_COMMA = 7'd1;
  localparam logic [6:0] CD_SEMI  = 7'd2;
  localparam logic [6:0] CD_LBR   = 7'd3;
  localparam logic [6:0] CD_RBR   = 7'd4;
  localparam logic [6:0] CD_EQ    = 7'd5;
  localparam logic [6:0] CD_NE    = 7'd6;
  localparam logic [6:0] CD_GT    = 7'd7;
  localparam logic [6:0] CD_GE    = 7'd8;
  localparam logic [6:0] CD_LT    = 7'd9;
  localparam logic [6:0] CD_LE    = 7'd10;
  localparam logic [6:0] CD_NOT   = 7'd11;
  localparam logic [6:0] CD_AND   = 7'd12;
  localparam logic [6:0] CD_OR    = 7'd13;
  localparam logic [6:0] CD_ADD   = 7'd15;
  localparam logic [6:0] CD_SUB   = 7'd16;
  localparam logic [6:0] CD_MUL   = 7'd17;
  localparam logic [6:0] CD_DIV   = 7'd18;
  localparam logic [6:0] CD_MOD   = 7'd19;
  localparam logic [6:0] CD_BAND  = 7'd20;
  localparam logic [6:0] CD_BOR   = 7'd21;
  localparam logic [6:0] CD_BXOR  = 7'd22;
  localparam logic [6:0] CD_NSTR  = 7'd23;
  localparam logic [6:0] CD_HSTR  = 7'd24;
  localparam logic [6:0] CD_BITS  = 7'd25;
  localparam logic [6:0] CD_WHERE = 7'd35;
  localparam logic [6:0] CD_SET   = 7'd37;

  // error codes
  localparam logic [2:0] ER_NONE = 3'd0;
  localparam logic [2:0] ER_NUM  = 3'd1;
  localparam logic [2:0] ER_STR  = 3'd2;
  localparam logic [2:0] ER_HEX  = 3'd3;
  localparam logic [2:0] ER_BITS = 3'd4;
  localparam logic [2:0] ER_CHAR = 3'd5;

  localparam logic [7:0] BIT_MAX = 8'd128;
  localparam int unsigned N_WORDS = 47;
  localparam int unsigned N_KEYWORDS = 42;
  localparam int unsigned WORD_MAX = 11;

  // right-justified upper-case words
  localparam logic [87:0] WORD_TXT [N_WORDS] = '{
    "AND", "OR", "NOT", "XOR", "CONNECT", "DISCONNECT", "SELECT", "INSERT",
    "UPDATE", "DELETE", "REPLACE", "UNION", "FROM", "WHERE", "AS", "SET",
    "INTO", "VALUES", "LIKE", "IN", "BETWEEN", "JOIN", "INNER", "LEFT",
    "RIGHT", "CREATE", "ALTER", "DROP", "DATABASE", "TABLE", "INDEX", "VIEW",
    "TRIGGER", "TRANSACTION", "BEGIN", "START", "COMMIT", "ROLLBACK", "MATCH",
    "AGAINST", "LIMIT", "TOP", "COUNT", "MIN", "MAX", "AVG", "SUM"};

  localparam logic [3:0] WORD_LEN [N_WORDS] = '{
    4'd3, 4'd2, 4'd3, 4'd3, 4'd7, 4'd10, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5,
    4'd4, 4'd5, 4'd2, 4'd3, 4'd4, 4'd6, 4'd4, 4'd2, 4'd7, 4'd4, 4'd5, 4'd4,
    4'd5, 4'd6, 4'd5, 4'd4, 4'd8, 4'd5, 4'd5, 4'd4, 4'd7, 4'd11, 4'd5, 4'd5,
    4'd6, 4'd8, 4'd5, 4'd7, 4'd5, 4'd3, 4'd5, 4'd3, 4'd3, 4'd3, 4'd3};

  localparam logic [6:0] WORD_CODE [N_WORDS] = '{
    7'd12, 7'd13, 7'd11, 7'd14, 7'd26, 7'd27, 7'd28, 7'd29, 7'd30, 7'd31,
    7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38, 7'd39, 7'd40, 7'd41,
    7'd42, 7'd43, 7'd44, 7'd45, 7'd46, 7'd47, 7'd48, 7'd49, 7'd50, 7'd51,
    7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd56, 7'd57, 7'd58, 7'd59, 7'd60,
    7'd61, 7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66};

  typedef struct packed {
    logic [3:0]  kind;
    logic [6:0]  code;
    logic [7:0]  data;
    logic        has;
    logic        done;
    logic [2:0]  err;
    logic [15:0] line;
  } res_t;

  typedef struct packed {
    res_t [2:0] r;
    logic [1:0] n;
  } lst_t;

  function automatic res_t mk(logic [3:0] kind, logic [6:0] code, logic [7:0] data,
                              logic has, logic done, logic [2:0] err,
                              logic [15:0] line);
    res_t o;
    o.kind = kind;
    o.code = code;
    o.data = data;
    o.has  = has;
    o.done = done;
    o.err  = err;
    o.line = line;
    return o;
  endfunction

  // append, silently dropping anything past three results
  function automatic lst_t put(lst_t l, res_t x);
    lst_t o;
    o = l;
    if (l.n != 2'd3) begin
      o.r[l.n] = x;
      o.n = l.n + 2'd1;
    end
    return o;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [7:0] upper(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) ? c - 8'd32 : c;
  endfunction

  // 16 means not a hex digit
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (is_digit(c)) v = 5'(c - "0");
    else if ((c >= "a") && (c <= "f")) v = 5'(c - "a" + 8'd10);
    else if ((c >= "A") && (c <= "F")) v = 5'(c - "A" + 8'd10);
    return v;
  endfunction

  function automatic logic is_sep(logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
           (c == 8'h0B) || (c == 8'h0C) || (c == ",") || (c == ";") ||
           (c == "(") || (c == ")") || (c == "=") || (c == "!") ||
           (c == ">") || (c == "<") || (c == "+") || (c == "-") ||
           (c == "*") || (c == "/") || (c == "%");
  endfunction

  // one-char form of a pending operator
  function automatic res_t op_tok(logic [7:0] qc, logic [15:0] line);
    res_t o;
    case (qc)
      "!":     o = mk(KD_LOG, CD_NOT, qc, 1'b1, 1'b1, ER_NONE, line);
      ">":     o = mk(KD_CMP, CD_GT, qc, 1'b1, 1'b1, ER_NONE, line);
      "<":     o = mk(KD_CMP, CD_LT, qc, 1'b1, 1'b1, ER_NONE, line);
      "&":     o = mk(KD_NUM, CD_BAND, qc, 1'b1, 1'b1, ER_NONE, line);
      default: o = mk(KD_NUM, CD_BOR, "|", 1'b1, 1'b1, ER_NONE, line);
    endcase
    return o;
  endfunction

endpackage

// ===== rtl/sql_token_lexer.sv =====
// ----------------------------------------------------------------------------
// sql_token_lexer
// Streaming SQL scanner: one text byte in, up to three token results out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one text byte per
//   transaction, with end_of_text_i on the final byte of a statement.
//   Output channel (out_valid_o/out_ready_i) carries one result per
//   transaction: a content byte (has_byte_o), a token completion
//   (token_done_o with kind_o and token_code_o), or an error (error_code_o).
//   last_result_o flags the final result caused by one input byte; a byte
//   may cause none (whitespace, a pending prefix).
// Queueing: the results of an accepted byte are registered into the queue.
// Throughput: one byte per cycle while the output drains one result per
//   cycle. All results of a byte are worked out together and written
//   into a four-entry result queue; a byte is taken only while at most one
//   entry is occupied, so a byte that yields two or three results holds off
//   the next byte until the queue has drained to one entry.
// Stall: when the receiver holds out_ready_i low, the queue fills and
//   in_ready_o drops; nothing is lost.
// Reset: scanner idle between tokens, line 1, queue empty.
// ----------------------------------------------------------------------------
module sql_token_lexer #(
  parameter int unsigned KEYWORD_LEN = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  kind_o,
  output logic [6:0]  token_code_o,
  output logic [7:0]  content_byte_o,
  output logic        has_byte_o,
  output logic        token_done_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] line_number_o,
  output logic        last_result_o
);

  localparam int unsigned IW = $clog2(KEYWORD_LEN);

  typedef logic [7:0] wbuf_t [KEYWORD_LEN];

  // scanner state
  stl_pkg::mode_e md_q, md_d;
  logic        af_q, af_d;       // '=' is assignment (after SET)
  logic [3:0]  pk_q, pk_d;       // kind of the previous token
  logic [15:0] ln_q, ln_d;
  logic [7:0]  qc_q, qc_d;       // quote or pending operator char
  logic        pt_q, pt_d;       // decimal point seen
  logic [4:0]  hn_q, hn_d;       // bit 4: high nibble held
  logic [7:0]  cc_q, cc_d;
  wbuf_t       wb_q, wb_d;

  // result queue
  stl_pkg::res_t q_mem [4];
  logic          q_last [4];
  logic [1:0]    wr_q, rd_q;
  logic [2:0]    cnt_q, cnt_d;

  stl_pkg::lst_t lst;
  logic in_acc, out_acc;

  // keyword ROM compare: {hit, aggregate, code}
  function automatic logic [8:0] lookup(wbuf_t wb, logic [7:0] cc);
    logic [8:0] r;
    logic       ok;
    r = '0;
    for (int e = stl_pkg::N_WORDS - 1; e >= 0; e--) begin
      ok = (cc == 8'(stl_pkg::WORD_LEN[e]));
      for (int i = 0; i < stl_pkg::WORD_MAX; i++) begin
        if (i < int'(stl_pkg::WORD_LEN[e])) begin
          if (wb[i] != stl_pkg::WORD_TXT[e][8*(int'(stl_pkg::WORD_LEN[e]) - 1 - i) +: 8])
            ok = 1'b0;
        end
      end
      if (ok) r = {1'b1, e >= stl_pkg::N_KEYWORDS, stl_pkg::WORD_CODE[e]};
    end
    return r;
  endfunction

  assign in_ready_o  = (cnt_q <= 3'd1);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_acc     = out_valid_o && out_ready_i;

  // one pass of the scanner; a byte that closes a token is rescanned
  always_comb begin
    logic       again;
    logic [7:0] c;
    logic [8:0] key;
    md_d = md_q; af_d = af_q; pk_d = pk_q; ln_d = ln_q; qc_d = qc_q;
    pt_d = pt_q; hn_d = hn_q; cc_d = cc_q; wb_d = wb_q;
    lst   = '0;
    again = 1'b1;
    c     = text_byte_i;
    key   = '0;
    for (int p = 0; p < 3; p++) begin
      if (again) begin
        again = 1'b0;
        unique case (md_d)
          stl_pkg::M_IDLE: begin
            if (c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0B || c == 8'h0C) begin
              md_d = stl_pkg::M_IDLE;
            end else if (c == 8'h0A) begin
              if (ln_d != 16'hFFFF) ln_d = ln_d + 16'd1;
            end else if (c == "," || c == ";" || c == "(" || c == ")" || c == "." ||
                         c == "=" || c == "+" || c == "*" || c == "/" || c == "%" ||
                         c == "^") begin
              case (c)
                ",":     begin pk_d = stl_pkg::KD_SYM;   key[6:0] = stl_pkg::CD_COMMA; end
                ";":     begin pk_d = stl_pkg::KD_SYM;   key[6:0] = stl_pkg::CD_SEMI;  end
                "(":     begin pk_d = stl_pkg::KD_SYM;   key[6:0] = stl_pkg::CD_LBR;   end
                ")":     begin pk_d = stl_pkg::KD_SYM;   key[6:0] = stl_pkg::CD_RBR;   end
                ".":     begin pk_d = stl_pkg::KD_POINT; key[6:0] = stl_pkg::CD_NONE;  end
                "=":     begin
                  pk_d = af_d ? stl_pkg::KD_ASSIGN : stl_pkg::KD_CMP;
                  key[6:0] = stl_pkg::CD_EQ;
                end
                "+":     begin pk_d = stl_pkg::KD_NUM;   key[6:0] = stl_pkg::CD_ADD;   end
                "*":     begin pk_d = stl_pkg::KD_NUM;   key[6:0] = stl_pkg::CD_MUL;   end
                "/":     begin pk_d = stl_pkg::KD_NUM;   key[6:0] = stl_pkg::CD_DIV;   end
                "%":     begin pk_d = stl_pkg::KD_NUM;   key[6:0] = stl_pkg::CD_MOD;   end
                default: begin pk_d = stl_pkg::KD_NUM;   key[6:0] = stl_pkg::CD_BXOR;  end
              endcase
              lst = stl_pkg::put(lst, stl_pkg::mk(pk_d, key[6:0], c, 1'b1, 1'b1,
                                                  stl_pkg::ER_NONE, ln_d));
            end else if (c == "!" || c == ">" || c == "<" || c == "&" || c == "|") begin
              qc_d = c; md_d = stl_pkg::M_OP;
            end else if (c == "-") begin
              if (pk_d == stl_pkg::KD_KEY || pk_d == stl_pkg::KD_SYM ||
                  pk_d == stl_pkg::KD_ASSIGN || pk_d == stl_pkg::KD_CMP ||
                  pk_d == stl_pkg::KD_LOG || pk_d == stl_pkg::KD_NUM) begin
                md_d = stl_pkg::M_MINUS;
              end else begin
                lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_NUM, stl_pkg::CD_SUB, c,
                                                    1'b1, 1'b1, stl_pkg::ER_NONE, ln_d));
                pk_d = stl_pkg::KD_NUM;
              end
            end else if (c == 8'h22 || c == 8'h27) begin
              qc_d = c; md_d = stl_pkg::M_STR;
            end else if (c == "x" || c == "X") begin
              qc_d = c; md_d = stl_pkg::M_XP;
            end else if (c == "b" || c == "B") begin
              qc_d = c; md_d = stl_pkg::M_BP;
            end else if (c == "0") begin
              md_d = stl_pkg::M_ZERO;
            end else if (stl_pkg::is_alpha(c)) begin
              cc_d = '0;
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              wb_d[cc_d[IW-1:0]] = stl_pkg::upper(c);
              cc_d = cc_d + 8'd1;
              md_d = stl_pkg::M_ID;
            end else if (stl_pkg::is_digit(c)) begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              pt_d = 1'b0; md_d = stl_pkg::M_NUM;
            end else begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                                  stl_pkg::ER_CHAR, ln_d));
              md_d = stl_pkg::M_DISCARD;
            end
          end
          stl_pkg::M_OP: begin
            if ((qc_d == "!" && c == "=") || (qc_d == ">" && c == "=") ||
                (qc_d == "<" && c == "=") || (qc_d == "<" && c == ">") ||
                (qc_d == "&" && c == "&") || (qc_d == "|" && c == "|")) begin
              if (qc_d == "!" || qc_d == ">" || qc_d == "<") pk_d = stl_pkg::KD_CMP;
              else pk_d = stl_pkg::KD_LOG;
              if (qc_d == "!" || c == ">") key[6:0] = stl_pkg::CD_NE;
              else if (qc_d == ">")        key[6:0] = stl_pkg::CD_GE;
              else if (qc_d == "<")        key[6:0] = stl_pkg::CD_LE;
              else if (qc_d == "&")        key[6:0] = stl_pkg::CD_AND;
              else                         key[6:0] = stl_pkg::CD_OR;
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, qc_d, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              lst = stl_pkg::put(lst, stl_pkg::mk(pk_d, key[6:0], c, 1'b1, 1'b1,
                                                  stl_pkg::ER_NONE, ln_d));
              md_d = stl_pkg::M_IDLE;
            end else begin
              lst  = stl_pkg::put(lst, stl_pkg::op_tok(qc_d, ln_d));
              pk_d = stl_pkg::op_tok(qc_d, ln_d).kind;
              md_d = stl_pkg::M_IDLE;
              again = 1'b1;
            end
          end
          stl_pkg::M_MINUS: begin
            if (stl_pkg::is_digit(c)) begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, "-", 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              pt_d = 1'b0; md_d = stl_pkg::M_NUM;
            end else begin
              lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_NUM, stl_pkg::CD_SUB, "-",
                                                  1'b1, 1'b1, stl_pkg::ER_NONE, ln_d));
              pk_d = stl_pkg::KD_NUM; md_d = stl_pkg::M_IDLE; again = 1'b1;
            end
          end
          stl_pkg::M_XP, stl_pkg::M_BP: begin
            if (c == 8'h22 || c == 8'h27) begin
              md_d = (md_d == stl_pkg::M_XP) ? stl_pkg::M_HEXQ : stl_pkg::M_BITQ;
              qc_d = c; hn_d = '0; cc_d = '0;
            end else begin
              cc_d = '0;
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, qc_d, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              wb_d[cc_d[IW-1:0]] = stl_pkg::upper(qc_d);
              cc_d = cc_d + 8'd1;
              md_d = stl_pkg::M_ID; again = 1'b1;
            end
          end
          stl_pkg::M_ZERO: begin
            if (c == "x" || c == "X") begin
              hn_d = '0; md_d = stl_pkg::M_HEX2;
            end else begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, "0", 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              pt_d = 1'b0; md_d = stl_pkg::M_NUM; again = 1'b1;
            end
          end
          stl_pkg::M_ID: begin
            if (stl_pkg::is_alpha(c) || stl_pkg::is_digit(c)) begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              if (cc_d < 8'(KEYWORD_LEN)) wb_d[cc_d[IW-1:0]] = stl_pkg::upper(c);
              if (cc_d != 8'hFF) cc_d = cc_d + 8'd1;
            end else begin
              key = lookup(wb_d, cc_d);
              if (!key[8]) begin
                pk_d = stl_pkg::KD_NAME; key[6:0] = stl_pkg::CD_NONE;
              end else if (key[7]) begin
                pk_d = stl_pkg::KD_AGG;
              end else begin
                pk_d = stl_pkg::KD_KEY;
                if (key[6:0] == stl_pkg::CD_SET) af_d = 1'b1;
                else if (key[6:0] == stl_pkg::CD_WHERE) af_d = 1'b0;
              end
              lst = stl_pkg::put(lst, stl_pkg::mk(pk_d, key[6:0], 8'd0, 1'b0, 1'b1,
                                                  stl_pkg::ER_NONE, ln_d));
              md_d = stl_pkg::M_IDLE; again = 1'b1;
            end
          end
          stl_pkg::M_NUM: begin
            if (stl_pkg::is_digit(c) || ((c == ".") && !pt_d)) begin
              if (c == ".") pt_d = 1'b1;
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
            end else if (c == ".") begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                                  stl_pkg::ER_NUM, ln_d));
              md_d = stl_pkg::M_DISCARD;
            end else if (c == "e" || c == "E") begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              md_d = stl_pkg::M_EXPS;
            end else begin
              pk_d = pt_d ? stl_pkg::KD_FLT : stl_pkg::KD_INT;
              lst = stl_pkg::put(lst, stl_pkg::mk(pk_d, stl_pkg::CD_NONE, 8'd0, 1'b0,
                                                  1'b1, stl_pkg::ER_NONE, ln_d));
              md_d = stl_pkg::M_IDLE; again = 1'b1;
            end
          end
          stl_pkg::M_EXPS: begin
            if (c == "+") begin
              md_d = stl_pkg::M_EXPD;
            end else if (c == "-" || stl_pkg::is_digit(c)) begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              md_d = stl_pkg::M_EXPD;
            end else begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                                  stl_pkg::ER_NUM, ln_d));
              md_d = stl_pkg::M_DISCARD;
            end
          end
          stl_pkg::M_EXPD: begin
            if (stl_pkg::is_digit(c)) begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
            end else begin
              pk_d = stl_pkg::KD_FLT;
              lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_FLT, stl_pkg::CD_NONE, 8'd0,
                                                  1'b0, 1'b1, stl_pkg::ER_NONE, ln_d));
              md_d = stl_pkg::M_IDLE; again = 1'b1;
            end
          end
          stl_pkg::M_STR: begin
            if (c == qc_d) begin
              pk_d = stl_pkg::KD_STR;
              lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_STR, stl_pkg::CD_NSTR, 8'd0,
                                                  1'b0, 1'b1, stl_pkg::ER_NONE, ln_d));
              md_d = stl_pkg::M_IDLE;
            end else if (c == 8'h5C) begin
              md_d = stl_pkg::M_ESC;
            end else begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
            end
          end
          stl_pkg::M_ESC: begin
            md_d = stl_pkg::M_STR;
            key[8] = 1'b1;
            case (c)
              "0":                     key[7:0] = 8'd0;
              8'h27, 8'h22, 8'h5C:     key[7:0] = c;
              "b":                     key[7:0] = 8'd8;
              "n":                     key[7:0] = 8'd10;
              "r":                     key[7:0] = 8'd13;
              "t":                     key[7:0] = 8'd9;
              default:                 key[8]   = 1'b0;
            endcase
            if (key[8]) begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, key[7:0], 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
            end else begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                                  stl_pkg::ER_STR, ln_d));
              md_d = stl_pkg::M_DISCARD;
            end
          end
          stl_pkg::M_HEXQ, stl_pkg::M_HEX2: begin
            if (md_d == stl_pkg::M_HEXQ && c == qc_d ||
                md_d == stl_pkg::M_HEX2 && stl_pkg::hex_val(c) == 5'd16 &&
                stl_pkg::is_sep(c)) begin
              // closing: an odd nibble count is a bad hex string
              if (hn_d[4]) begin
                lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                                    stl_pkg::ER_HEX, ln_d));
                md_d = stl_pkg::M_DISCARD;
              end else begin
                again = (md_d == stl_pkg::M_HEX2);
                pk_d = stl_pkg::KD_STR;
                lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_STR, stl_pkg::CD_HSTR,
                                                    8'd0, 1'b0, 1'b1, stl_pkg::ER_NONE,
                                                    ln_d));
                md_d = stl_pkg::M_IDLE;
              end
            end else if (stl_pkg::hex_val(c) != 5'd16) begin
              if (hn_d[4]) begin
                lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0,
                                                    {hn_d[3:0], stl_pkg::hex_val(c)[3:0]},
                                                    1'b1, 1'b0, stl_pkg::ER_NONE, ln_d));
                hn_d = '0;
              end else begin
                hn_d = {1'b1, stl_pkg::hex_val(c)[3:0]};
              end
            end else begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                                  stl_pkg::ER_HEX, ln_d));
              md_d = stl_pkg::M_DISCARD;
            end
          end
          stl_pkg::M_BITQ: begin
            if (c == qc_d) begin
              pk_d = stl_pkg::KD_INT;
              lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_INT, stl_pkg::CD_BITS, 8'd0,
                                                  1'b0, 1'b1, stl_pkg::ER_NONE, ln_d));
              md_d = stl_pkg::M_IDLE;
            end else if ((c == "0" || c == "1") && cc_d < stl_pkg::BIT_MAX) begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, c, 1'b1, 1'b0,
                                                  stl_pkg::ER_NONE, ln_d));
              cc_d = cc_d + 8'd1;
            end else begin
              lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                                  stl_pkg::ER_BITS, ln_d));
              md_d = stl_pkg::M_DISCARD;
            end
          end
          default: ;
        endcase
      end
    end

    // end of text: close the pending token, then back to the reset state
    if (end_of_text_i) begin
      unique case (md_d)
        stl_pkg::M_OP: lst = stl_pkg::put(lst, stl_pkg::op_tok(qc_d, ln_d));
        stl_pkg::M_MINUS:
          lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_NUM, stl_pkg::CD_SUB, "-",
                                              1'b1, 1'b1, stl_pkg::ER_NONE, ln_d));
        stl_pkg::M_XP, stl_pkg::M_BP:
          lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_NAME, stl_pkg::CD_NONE, qc_d,
                                              1'b1, 1'b1, stl_pkg::ER_NONE, ln_d));
        stl_pkg::M_ZERO:
          lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_INT, stl_pkg::CD_NONE, "0",
                                              1'b1, 1'b1, stl_pkg::ER_NONE, ln_d));
        stl_pkg::M_ID: begin
          key = lookup(wb_d, cc_d);
          lst = stl_pkg::put(lst, stl_pkg::mk(!key[8] ? stl_pkg::KD_NAME :
                                              key[7] ? stl_pkg::KD_AGG : stl_pkg::KD_KEY,
                                              key[8] ? key[6:0] : stl_pkg::CD_NONE, 8'd0,
                                              1'b0, 1'b1, stl_pkg::ER_NONE, ln_d));
        end
        stl_pkg::M_NUM:
          lst = stl_pkg::put(lst, stl_pkg::mk(pt_d ? stl_pkg::KD_FLT : stl_pkg::KD_INT,
                                              stl_pkg::CD_NONE, 8'd0, 1'b0, 1'b1,
                                              stl_pkg::ER_NONE, ln_d));
        stl_pkg::M_EXPS:
          lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                              stl_pkg::ER_NUM, ln_d));
        stl_pkg::M_EXPD:
          lst = stl_pkg::put(lst, stl_pkg::mk(stl_pkg::KD_FLT, stl_pkg::CD_NONE, 8'd0,
                                              1'b0, 1'b1, stl_pkg::ER_NONE, ln_d));
        stl_pkg::M_STR, stl_pkg::M_ESC:
          lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                              stl_pkg::ER_STR, ln_d));
        stl_pkg::M_HEXQ:
          lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                              stl_pkg::ER_HEX, ln_d));
        stl_pkg::M_HEX2:
          lst = stl_pkg::put(lst, hn_d[4] ?
                             stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0, stl_pkg::ER_HEX,
                                         ln_d) :
                             stl_pkg::mk(stl_pkg::KD_STR, stl_pkg::CD_HSTR, 8'd0, 1'b0,
                                         1'b1, stl_pkg::ER_NONE, ln_d));
        stl_pkg::M_BITQ:
          lst = stl_pkg::put(lst, stl_pkg::mk(4'd0, 7'd0, 8'd0, 1'b0, 1'b0,
                                              stl_pkg::ER_BITS, ln_d));
        default: ;
      endcase
      md_d = stl_pkg::M_IDLE;
      af_d = 1'b0;
      pk_d = stl_pkg::KD_NONE;
      ln_d = 16'd1;
      qc_d = '0;
      pt_d = 1'b0;
      hn_d = '0;
      cc_d = '0;
    end
  end

  assign cnt_d = cnt_q + (in_acc ? {1'b0, lst.n} : 3'd0) - (out_acc ? 3'd1 : 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_q  <= stl_pkg::M_IDLE;
      af_q  <= 1'b0;
      pk_q  <= stl_pkg::KD_NONE;
      ln_q  <= 16'd1;
      qc_q  <= '0;
      pt_q  <= 1'b0;
      hn_q  <= '0;
      cc_q  <= '0;
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (in_acc) begin
        md_q <= md_d;
        af_q <= af_d;
        pk_q <= pk_d;
        ln_q <= ln_d;
        qc_q <= qc_d;
        pt_q <= pt_d;
        hn_q <= hn_d;
        cc_q <= cc_d;
        wr_q <= wr_q + lst.n;
      end
      if (out_acc) rd_q <= rd_q + 2'd1;
      cnt_q <= cnt_d;
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      wb_q <= wb_d;
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < lst.n) begin
          q_mem[wr_q + 2'(k)]  <= lst.r[k];
          q_last[wr_q + 2'(k)] <= (2'(k) == lst.n - 2'd1);
        end
      end
    end
  end

  assign kind_o         = q_mem[rd_q].kind;
  assign token_code_o   = q_mem[rd_q].code;
  assign content_byte_o = q_mem[rd_q].data;
  assign has_byte_o     = q_mem[rd_q].has;
  assign token_done_o   = q_mem[rd_q].done;
  assign error_code_o   = q_mem[rd_q].err;
  assign line_number_o  = q_mem[rd_q].line;
  assign last_result_o  = q_last[rd_q];

  // queue never overflows its four entries
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result queue overflow");

  // results of one byte are queued together, so a non-final one has company
  a_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_result_o |=> out_valid_o) else $error("result group split");

  // end of text returns the scanner to its start state
  a_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && end_of_text_i |=> md_q == stl_pkg::M_IDLE && ln_q == 16'd1)
    else $error("scanner not reset at end of text");

  a_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ln_q != 16'd0) else $error("line count wrapped");

  a_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(md_q)) else $error("scan mode not one-hot");

endmodule
